[src/sfp_pkg.sv]
// Shared types, constants and helper functions for the sync-framed packet parser.
package sfp_pkg;

  localparam int FRAME_BYTES_DEF = 138;
  localparam int STORE_DEPTH     = 256;
  localparam int POS_W           = 8;
  localparam int FILL_W          = POS_W + 1;
  localparam int MEM_DEPTH       = 2 * STORE_DEPTH;
  localparam int MEM_AW          = POS_W + 1;
  localparam int FIELD_COUNT     = 28;
  localparam int FIELD_W         = 5;
  localparam int HDR_BYTES       = 10;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] SYNC_FIRST  = 8'hFA;
  localparam logic [7:0] SYNC_SECOND = 8'h1B;

  typedef enum logic [1:0] {
    STAT_FIELD = 2'd0,
    STAT_HDR   = 2'd1,
    STAT_CRC   = 2'd2
  } status_e;

  typedef struct packed {
    status_e status;
    logic    bank;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  // Byte offsets of the payload fields within the frame.
  localparam logic [7:0] FLD_OFFSET [FIELD_COUNT] = '{
    8'd10, 8'd18, 8'd26, 8'd30, 8'd34, 8'd38, 8'd46, 8'd54, 8'd62, 8'd66,
    8'd70, 8'd74, 8'd78, 8'd82, 8'd86, 8'd87, 8'd88, 8'd92, 8'd96, 8'd100,
    8'd104, 8'd108, 8'd112, 8'd116, 8'd120, 8'd124, 8'd128, 8'd132
  };

  // Index of the last byte of each field (field size minus one).
  localparam logic [2:0] FLD_LAST [FIELD_COUNT] = '{
    3'd7, 3'd7, 3'd3, 3'd3, 3'd3, 3'd7, 3'd7, 3'd7, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd0, 3'd0, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3
  };

  // Expected header byte at a given frame position.
  function automatic logic [7:0] hdr_byte(input logic [3:0] pos);
    logic [7:0] b;
    case (pos)
      4'd0:    b = 8'hFA;
      4'd1:    b = 8'h1B;
      4'd2:    b = 8'hE3;
      4'd3:    b = 8'h01;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h02;
      4'd6:    b = 8'h90;
      4'd7:    b = 8'h00;
      4'd8:    b = 8'h42;
      4'd9:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // One byte of CRC-16 with polynomial 0x1021, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ 16'h1021;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[src/sfp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sfp_ram #(
  parameter int Width = 8,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/sfp_front.sv]
// Front end: sync detection, frame fill, header and running CRC check.
module sfp_front
  import sfp_pkg::*;
#(
  parameter int FrameBytes = FRAME_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic [7:0] byte_in_i,
  output logic      in_stall_o,
  input  logic      q_full_i,
  output logic      push_o,
  output cmd_t      push_cmd_o,
  input  bank_rel_t rel_i,
  output mem_wr_t   mem_wr_o
);

  logic [7:0]        prev_q, prev_d;
  logic              in_frame_q, in_frame_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              hdr_ok_q, hdr_ok_d;
  logic [15:0]       crc_q, crc_d;
  logic              wr_bank_q, wr_bank_d;
  logic [1:0]        busy_q, busy_d;

  logic              accept;
  logic              sync;
  logic              hdr_ok_n;
  logic [15:0]       crc_n;
  logic [FILL_W-1:0] fill_n;

  // Stall while the queue is full or while both frame banks await readout.
  assign in_stall_o = q_full_i | busy_q[wr_bank_q];
  assign accept     = in_valid_i & ~in_stall_o;
  assign sync       = (byte_in_i == SYNC_SECOND) && (prev_q == SYNC_FIRST);

  always_comb begin
    prev_d     = prev_q;
    in_frame_d = in_frame_q;
    fill_d     = fill_q;
    hdr_ok_d   = hdr_ok_q;
    crc_d      = crc_q;
    wr_bank_d  = wr_bank_q;
    busy_d     = busy_q;
    push_o     = 1'b0;
    push_cmd_o = '{status: STAT_FIELD, bank: wr_bank_q};
    mem_wr_o   = '{en: 1'b0, addr: {wr_bank_q, fill_q[POS_W-1:0]}, data: byte_in_i};
    hdr_ok_n   = hdr_ok_q & ((fill_q >= FILL_W'(HDR_BYTES)) ||
                             (byte_in_i == hdr_byte(fill_q[3:0])));
    crc_n      = crc_byte(crc_q, byte_in_i);
    fill_n     = fill_q + FILL_W'(1);

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (accept) begin
      prev_d = byte_in_i;
      if (sync) begin
        // The two sync bytes are never read back, so they are not stored.
        in_frame_d = 1'b1;
        fill_d     = FILL_W'(2);
        hdr_ok_d   = 1'b1;
        crc_d      = crc_byte(16'h0000, SYNC_SECOND);
      end else if (in_frame_q) begin
        mem_wr_o.en = 1'b1;
        fill_d      = fill_n;
        hdr_ok_d    = hdr_ok_n;
        crc_d       = crc_n;
        if (fill_n == FILL_W'(FrameBytes)) begin
          in_frame_d = 1'b0;
          push_o     = 1'b1;
          if (!hdr_ok_n) begin
            push_cmd_o.status = STAT_HDR;
          end else if (crc_n != 16'h0000) begin
            push_cmd_o.status = STAT_CRC;
          end else begin
            push_cmd_o.status = STAT_FIELD;
            busy_d[wr_bank_q] = 1'b1;
            wr_bank_d         = ~wr_bank_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      in_frame_q <= 1'b0;
      fill_q     <= '0;
      hdr_ok_q   <= 1'b0;
      crc_q      <= '0;
      wr_bank_q  <= 1'b0;
      busy_q     <= '0;
    end else begin
      prev_q     <= prev_d;
      in_frame_q <= in_frame_d;
      fill_q     <= fill_d;
      hdr_ok_q   <= hdr_ok_d;
      crc_q      <= crc_d;
      wr_bank_q  <= wr_bank_d;
      busy_q     <= busy_d;
    end
  end

  // While a frame is open, its fill stays between the sync pair and the frame size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> (fill_q >= FILL_W'(2)) && (fill_q < FILL_W'(FrameBytes)))
    else $error("frame fill count out of range");

  // A released bank must be one that was handed to the back end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_i.valid |-> busy_q[rel_i.bank])
    else $error("release of a bank that is not busy");

endmodule

[src/sfp_cmdq.sv]
// Small command queue between the front end and the back end.
module sfp_cmdq
  import sfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic not_empty_o,
  output logic full_o
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           entry_q [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] count_q, count_d;
  logic           do_push, do_pop;

  assign full_o      = (count_q == QCW'(QUEUE_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign head_o      = entry_q[rd_ptr_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = pop_i & not_empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + QCW'(1);
      2'b01:   count_d = count_q - QCW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // The front end holds its input whenever the queue is full, so no push is lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");

endmodule

[src/sfp_back.sv]
// Back end: reads payload fields from the frame RAM and emits result transactions.
module sfp_back
  import sfp_pkg::*;
#(
  parameter int FrameBytes = FRAME_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_not_empty_i,
  input  cmd_t               q_head_i,
  output logic               q_pop_o,
  output mem_rd_t            mem_rd_o,
  input  logic [7:0]         rd_data_i,
  output bank_rel_t          rel_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [FIELD_W-1:0] field_index_o,
  output logic [63:0]        field_value_o,
  output logic               last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_ACCUM,
    S_EMIT,
    S_STAT
  } state_e;

  state_e             state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [FIELD_W-1:0] field_q, field_d;
  logic [2:0]         idx_q, idx_d;
  logic [63:0]        acc_q, acc_d;
  logic               oob_q, oob_d;
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [FIELD_W-1:0] out_index_q, out_index_d;
  logic [63:0]        out_value_q, out_value_d;
  logic               out_last_q, out_last_d;

  logic [POS_W-1:0]   pos;
  logic [7:0]         byte_v;
  logic               out_free;
  logic               last_field;

  assign pos        = FLD_OFFSET[field_q] + {5'd0, idx_q};
  assign byte_v     = oob_q ? 8'h00 : rd_data_i;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign last_field = (field_q == FIELD_W'(FIELD_COUNT - 1));

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    field_d      = field_q;
    idx_d        = idx_q;
    acc_d        = acc_q;
    oob_d        = oob_q;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q & out_stall_i;
    q_pop_o      = 1'b0;
    mem_rd_o     = '{en: 1'b0, addr: {cmd_q.bank, pos}};
    rel_o        = '{valid: 1'b0, bank: cmd_q.bank};

    unique case (state_q)
      S_IDLE: begin
        if (q_not_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_head_i;
          field_d = '0;
          idx_d   = '0;
          acc_d   = '0;
          state_d = (q_head_i.status == STAT_FIELD) ? S_FETCH : S_STAT;
        end
      end
      S_FETCH: begin
        // Bytes past the frame end read as zero.
        mem_rd_o.en = 1'b1;
        oob_d       = ({1'b0, pos} >= FILL_W'(FrameBytes));
        state_d     = S_ACCUM;
      end
      S_ACCUM: begin
        for (int k = 0; k < 8; k++) begin
          if (idx_q == 3'(k)) begin
            acc_d[8*k +: 8] = byte_v;
          end
        end
        if (idx_q == FLD_LAST[field_q]) begin
          state_d = S_EMIT;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = S_FETCH;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_FIELD;
          out_index_d  = field_q;
          out_value_d  = acc_q;
          out_last_d   = last_field;
          if (last_field) begin
            rel_o.valid = 1'b1;
            state_d     = S_IDLE;
          end else begin
            field_d = field_q + FIELD_W'(1);
            idx_d   = '0;
            acc_d   = '0;
            state_d = S_FETCH;
          end
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = cmd_q.status;
          out_index_d  = '0;
          out_value_d  = '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '{status: STAT_FIELD, bank: 1'b0};
      field_q      <= '0;
      idx_q        <= '0;
      acc_q        <= '0;
      oob_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= STAT_FIELD;
      out_index_q  <= '0;
      out_value_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      field_q      <= field_d;
      idx_q        <= idx_d;
      acc_q        <= acc_d;
      oob_q        <= oob_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_index_q  <= out_index_d;
      out_value_q  <= out_value_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign field_index_o = out_index_q;
  assign field_value_o = out_value_q;
  assign last_o        = out_last_q;

  // A header or checksum failure is a single, final transaction with empty fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != STAT_FIELD) |->
      out_last_q && (out_index_q == '0) && (out_value_q == '0))
    else $error("status transaction carries field data");

  // A field transaction is marked last exactly when it is the final payload field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == STAT_FIELD) |->
      (out_last_q == (out_index_q == FIELD_W'(FIELD_COUNT - 1))))
    else $error("last flag does not match field index");

endmodule

[src/sync_framed_packet_crc_parser.sv]
// Top level of the sync-framed packet parser with CRC-16 check.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+-------------------------------------
//   input   | in        | in_valid_i / in_stall_o  | byte_in_i[7:0]
//   output  | out       | out_valid_o / out_stall_i| status_o, field_index_o,
//           |           |                          | field_value_o[63:0], last_o
//
// The front end takes one byte per cycle whenever it is not stalling.
// The back end takes a command, then for each payload byte issues a registered RAM read
// and accumulates the returned byte, and emits each assembled field as its own transaction.
// The input stalls only while both frame banks wait for readout or the command queue is full.
// A result waits in the output register; the front end keeps taking bytes meanwhile.
// Reset is asynchronous and active low; the frame RAM needs no clearing pass.
//
// A frame starts when the byte 0xFA is followed by 0x1B, and a new sync pair restarts the
// frame even part way through one. The front end stores each frame byte into one of two
// RAM banks and checks the fixed ten-byte header and the CRC-16 (polynomial 0x1021,
// initial value zero) on the fly, one byte per cycle unless stalled. When the frame is complete it pushes
// a command into a short queue: either a status (header mismatch or checksum failure), or
// a request to read the payload out of the bank it just filled. The back end pops commands
// and either sends one status transaction or walks the 28 payload fields, assembling each
// little-endian value byte by byte and sending one transaction per field.
module sync_framed_packet_crc_parser
  import sfp_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         byte_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [FIELD_W-1:0] field_index_o,
  output logic [63:0]        field_value_o,
  output logic               last_o
);

  logic      q_full;
  logic      q_not_empty;
  logic      q_push;
  logic      q_pop;
  cmd_t      q_push_cmd;
  cmd_t      q_head;
  bank_rel_t bank_rel;
  mem_wr_t   mem_wr;
  mem_rd_t   mem_rd;
  logic [7:0] rd_data;

  // Front end: sync detection, frame storage, header and CRC checks.
  sfp_front #(
    .FrameBytes(FRAME_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .byte_in_i  (byte_in_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .push_cmd_o (q_push_cmd),
    .rel_i      (bank_rel),
    .mem_wr_o   (mem_wr)
  );

  // Command queue decoupling the two halves.
  sfp_cmdq u_cmdq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_cmd_i  (q_push_cmd),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .not_empty_o (q_not_empty),
    .full_o      (q_full)
  );

  // Two frame banks of STORE_DEPTH bytes each.
  sfp_ram #(
    .Width(8),
    .Depth(MEM_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr.en),
    .wr_addr_i (mem_wr.addr),
    .wr_data_i (mem_wr.data),
    .rd_en_i   (mem_rd.en),
    .rd_addr_i (mem_rd.addr),
    .rd_data_o (rd_data)
  );

  // Back end: field readout and result transactions.
  sfp_back #(
    .FrameBytes(FRAME_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .mem_rd_o      (mem_rd),
    .rd_data_i     (rd_data),
    .rel_o         (bank_rel),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .field_index_o (field_index_o),
    .field_value_o (field_value_o),
    .last_o        (last_o)
  );

endmodule
